>>> design/slfr_pkg.sv
// ----------------------------------------------------------------------------
// slfr_pkg
// Shared types and constants for the sync/length frame receiver.
// ----------------------------------------------------------------------------
package slfr_pkg;

  // item kind on the input channel
  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } cmd_t;

  localparam logic [7:0]  SYNC_BYTE      = 8'hAA;
  localparam int          TOTAL_W        = 17;
  localparam int          POS_W          = 10;
  localparam int          TICK_W         = 32;
  localparam int          FRAME_BASE_LEN = 8;
  localparam int          LEN_LO_POS     = 4;
  localparam int          LEN_HI_POS     = 5;
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 32'd1000;

  // one result word
  typedef struct packed {
    logic [7:0]       data_byte;
    logic [POS_W-1:0] position;
    logic             frame_end;
    logic             frame_abort;
    logic             timed_out;
  } result_t;

endpackage

>>> design/slfr_frame_ctl.sv
// ----------------------------------------------------------------------------
// slfr_frame_ctl
// Frame state, tick timer and timeout register; works out the result for
// the held word and updates state when the word is retired.
// ----------------------------------------------------------------------------
module slfr_frame_ctl #(
  parameter int MAX_FRAME_BYTES = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [slfr_pkg::TICK_W-1:0]      cfg_timeout,
  input  logic                             step,
  input  slfr_pkg::cmd_t                   cmd,
  input  logic [7:0]                       rx_byte,
  output logic                             has_result,
  output slfr_pkg::result_t                result
);

  localparam int CountW = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [CountW-1:0] MaxCount = CountW'(MAX_FRAME_BYTES);
  localparam logic [slfr_pkg::TOTAL_W-1:0] MaxTotal =
    slfr_pkg::TOTAL_W'(MAX_FRAME_BYTES);
  localparam logic [slfr_pkg::TOTAL_W-1:0] MinTotal =
    slfr_pkg::TOTAL_W'(slfr_pkg::FRAME_BASE_LEN);
  localparam logic [CountW-1:0] LenLoPos = CountW'(slfr_pkg::LEN_LO_POS);
  localparam logic [CountW-1:0] LenHiPos = CountW'(slfr_pkg::LEN_HI_POS);

  logic [CountW-1:0]                byte_count, byte_count_next;
  logic [7:0]                       length_low_byte, length_low_byte_next;
  logic [slfr_pkg::TOTAL_W-1:0]     needed_total, needed_total_next;
  logic [slfr_pkg::TICK_W-1:0]      elapsed_ticks, elapsed_ticks_next;
  logic [slfr_pkg::TICK_W-1:0]      timeout_ticks;

  logic [slfr_pkg::TICK_W-1:0]      tick_sum;
  logic [CountW-1:0]                count_inc;
  logic [slfr_pkg::TOTAL_W-1:0]     total_calc;
  logic [slfr_pkg::TOTAL_W-1:0]     eff_total;

  assign tick_sum   = elapsed_ticks + 1'b1;
  assign count_inc  = byte_count + 1'b1;
  assign total_calc = MinTotal + slfr_pkg::TOTAL_W'({rx_byte, length_low_byte});
  assign eff_total  = (byte_count == LenHiPos) ? total_calc : needed_total;

  // next state and result for the held word
  always_comb begin
    byte_count_next      = byte_count;
    length_low_byte_next = length_low_byte;
    needed_total_next    = needed_total;
    elapsed_ticks_next   = elapsed_ticks;
    has_result           = 1'b0;
    result               = '0;
    case (cmd)
      slfr_pkg::CMD_TICK: begin
        if (tick_sum >= timeout_ticks) begin
          byte_count_next    = '0;
          needed_total_next  = MinTotal;
          elapsed_ticks_next = '0;
          has_result         = 1'b1;
          result.timed_out   = 1'b1;
        end else begin
          elapsed_ticks_next = tick_sum;
        end
      end
      slfr_pkg::CMD_BYTE: begin
        if (byte_count == '0 && rx_byte != slfr_pkg::SYNC_BYTE) begin
          // hunting: drop the byte
          byte_count_next = byte_count;
        end else if (byte_count >= MaxCount) begin
          // buffer-full guard
          byte_count_next = '0;
        end else begin
          byte_count_next  = count_inc;
          has_result       = 1'b1;
          result.data_byte = rx_byte;
          result.position  = slfr_pkg::POS_W'(byte_count);
          if (byte_count == LenLoPos) begin
            length_low_byte_next = rx_byte;
          end
          if (byte_count == LenHiPos) begin
            needed_total_next = total_calc;
          end
          if (byte_count == LenHiPos && total_calc > MaxTotal) begin
            // declared length does not fit the buffer
            byte_count_next    = '0;
            needed_total_next  = MinTotal;
            result.frame_abort = 1'b1;
          end else if (slfr_pkg::TOTAL_W'(count_inc) >= eff_total) begin
            byte_count_next    = '0;
            needed_total_next  = MinTotal;
            elapsed_ticks_next = '0;
            result.frame_end   = 1'b1;
          end
        end
      end
      default: begin
        has_result = 1'b0;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      length_low_byte <= '0;
      needed_total    <= MinTotal;
      elapsed_ticks   <= '0;
    end else if (step) begin
      byte_count      <= byte_count_next;
      length_low_byte <= length_low_byte_next;
      needed_total    <= needed_total_next;
      elapsed_ticks   <= elapsed_ticks_next;
    end
  end

  // timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= slfr_pkg::TIMEOUT_RESET;
    end else if (cfg_write) begin
      timeout_ticks <= cfg_timeout;
    end
  end

endmodule

>>> design/slfr_result_reg.sv
// ----------------------------------------------------------------------------
// slfr_result_reg
// Output register holding one result word until the sink takes it.
// ----------------------------------------------------------------------------
module slfr_result_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  slfr_pkg::result_t load_data,
  output logic              free,
  input  logic              out_stall,
  output logic              out_valid,
  output slfr_pkg::result_t out_data
);

  // room for a new word when empty or when the held word leaves now
  assign free = !out_valid || !out_stall;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_data;
    end
  end

endmodule

>>> design/sync_length_frame_receiver.sv
// ----------------------------------------------------------------------------
// sync_length_frame_receiver
// Receives bytes and millisecond ticks, finds 0xAA-synced length-prefixed
// frames and reports each stored byte, aborted frames and timeouts.
// ----------------------------------------------------------------------------
// One item (byte or tick) is accepted every clock cycle unless in_stall is set.
// An accepted item lands in an input register; when the held item retires, the
// frame state and tick timer are updated and any result is loaded into the
// output register, which drives the output ports. The input side stalls
// only when the held item has a result and the output register is full and
// stalled. The timeout register is written through the cfg channel, always
// ready.
module sync_length_frame_receiver #(
  parameter int MAX_FRAME_BYTES = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [slfr_pkg::TICK_W-1:0]  timeout_ticks,
  // input items
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         cmd,
  input  logic [7:0]                   rx_byte,
  // results
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   data_byte,
  output logic [slfr_pkg::POS_W-1:0]   position,
  output logic                         frame_end,
  output logic                         frame_abort,
  output logic                         timed_out
);

  logic              s1_valid;
  slfr_pkg::cmd_t    s1_cmd;
  logic [7:0]        s1_byte;
  logic              s1_go;
  logic              has_result;
  logic              res_free;
  slfr_pkg::result_t result;
  slfr_pkg::result_t out_data;

  assign cfg_ready = 1'b1;

  // held item retires when it has no result or the output register has room
  assign s1_go    = s1_valid && (!has_result || res_free);
  assign in_stall = s1_valid && !s1_go;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_cmd  <= slfr_pkg::cmd_t'(cmd);
      s1_byte <= rx_byte;
    end
  end

  slfr_frame_ctl #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_ctl (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_timeout(timeout_ticks),
    .step       (s1_go),
    .cmd        (s1_cmd),
    .rx_byte    (s1_byte),
    .has_result (has_result),
    .result     (result)
  );

  slfr_result_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (s1_go && has_result),
    .load_data (result),
    .free      (res_free),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign data_byte   = out_data.data_byte;
  assign position    = out_data.position;
  assign frame_end   = out_data.frame_end;
  assign frame_abort = out_data.frame_abort;
  assign timed_out   = out_data.timed_out;

  // at most one kind of flag per result
  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones({frame_end, frame_abort, timed_out}) <= 1)
    else $error("result carries more than one flag");

  // timeout result carries no byte
  a_timeout_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && timed_out) |-> (data_byte == 8'd0 && position == '0))
    else $error("timeout result with nonzero data");

  // abort only on the length high byte
  a_abort_pos: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_abort) |-> position == slfr_pkg::POS_W'(slfr_pkg::LEN_HI_POS))
    else $error("frame abort away from length byte");

  // a stalled held item with a result means the output is full
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && has_result))
    else $error("input stalled without a full output");

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the sync/length frame receiver. Bytes and ticks
// go in through a valid/stall sender and results come out through a
// valid/stall receiver, both with random idle bursts. A behavioral model of
// the hunt/store/length/timeout logic predicts every result word, and each
// received word is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_FRAME  = 1024;
  // no-progress limit: longest legal quiet stretch is a sender gap or a
  // receiver stall plus the short drain pause
  localparam int HANG_LIMIT = 1000;
  localparam int DRAIN_WAIT = 6;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [slfr_pkg::TICK_W-1:0] cfg_timeout = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  slfr_pkg::cmd_t              cmd_in = slfr_pkg::CMD_BYTE;
  logic [7:0]                  rx_in = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [7:0]                  got_data;
  logic [slfr_pkg::POS_W-1:0]  got_pos;
  logic                        got_end;
  logic                        got_abort;
  logic                        got_tmo;

  // predictor state
  int unsigned                 frame_fill;
  int unsigned                 frame_total;
  logic [7:0]                  len_lo;
  logic [slfr_pkg::TICK_W-1:0] tick_count;
  logic [slfr_pkg::TICK_W-1:0] timeout_reg;
  slfr_pkg::result_t           expected_words[$];

  // run bookkeeping
  bit gaps_on = 1'b1;
  int stall_left;
  int hang_cycles;
  int sent_items;
  int checked_words;
  int n_errors;
  int n_frames;
  int n_aborts;
  int n_timeouts;

  sync_length_frame_receiver #(
    .MAX_FRAME_BYTES(MAX_FRAME)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .timeout_ticks(cfg_timeout),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd_in),
    .rx_byte      (rx_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .data_byte    (got_data),
    .position     (got_pos),
    .frame_end    (got_end),
    .frame_abort  (got_abort),
    .timed_out    (got_tmo)
  );

  always #5 clk = ~clk;

  // frame receiver prediction for one accepted word
  function automatic bit frame_rx_predict(input slfr_pkg::cmd_t c, input logic [7:0] b,
                                          output slfr_pkg::result_t r);
    int unsigned slot;
    r = '0;
    if (c == slfr_pkg::CMD_TICK) begin
      tick_count = tick_count + 1'b1;
      if (tick_count >= timeout_reg) begin
        frame_fill  = 0;
        frame_total = slfr_pkg::FRAME_BASE_LEN;
        tick_count  = '0;
        r.timed_out = 1'b1;
        n_timeouts++;
        return 1'b1;
      end
      return 1'b0;
    end
    // hunting drops everything but sync
    if (frame_fill == 0 && b != slfr_pkg::SYNC_BYTE) return 1'b0;
    // buffer-full guard
    if (frame_fill >= MAX_FRAME) begin
      frame_fill = 0;
      return 1'b0;
    end
    slot = frame_fill;
    frame_fill++;
    r.data_byte = b;
    r.position  = slot[slfr_pkg::POS_W-1:0];
    if (slot == slfr_pkg::LEN_LO_POS) len_lo = b;
    if (slot == slfr_pkg::LEN_HI_POS) begin
      frame_total = slfr_pkg::FRAME_BASE_LEN + {b, len_lo};
      if (frame_total > MAX_FRAME) begin
        frame_fill    = 0;
        frame_total   = slfr_pkg::FRAME_BASE_LEN;
        r.frame_abort = 1'b1;
        n_aborts++;
        return 1'b1;
      end
    end
    if (frame_fill >= frame_total) begin
      frame_fill  = 0;
      frame_total = slfr_pkg::FRAME_BASE_LEN;
      tick_count  = '0;
      r.frame_end = 1'b1;
      n_frames++;
    end
    return 1'b1;
  endfunction

  task automatic flag_error(input string msg);
    n_errors++;
    if (n_errors <= 10) $display("ERROR: %s", msg);
  endtask

  // send one word, optionally after a random gap
  task automatic send_word(input slfr_pkg::cmd_t c, input logic [7:0] b);
    slfr_pkg::result_t r;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd_in   <= c;
    rx_in    <= b;
    do @(posedge clk); while (in_stall);
    sent_items++;
    if (frame_rx_predict(c, b, r)) expected_words.push_back(r);
  endtask

  task automatic send_tick();
    send_word(slfr_pkg::CMD_TICK, 8'($urandom));
  endtask

  // one frame: sync, three header bytes, length, body, trailer;
  // oversized frames stop after the length, cut_at truncates early
  task automatic send_frame(input int unsigned body_len, input int unsigned cut_at,
                            input int tick_pct);
    int unsigned n_bytes;
    logic [15:0] len16;
    logic [7:0]  b;
    len16   = body_len[15:0];
    n_bytes = body_len + slfr_pkg::FRAME_BASE_LEN;
    if (n_bytes > MAX_FRAME) n_bytes = slfr_pkg::LEN_HI_POS + 1;
    if (cut_at < n_bytes) n_bytes = cut_at;
    for (int unsigned i = 0; i < n_bytes; i++) begin
      if ($urandom_range(0, 99) < tick_pct) send_tick();
      case (i)
        0:                   b = slfr_pkg::SYNC_BYTE;
        slfr_pkg::LEN_LO_POS: b = len16[7:0];
        slfr_pkg::LEN_HI_POS: b = len16[15:8];
        default:             b = 8'($urandom);
      endcase
      send_word(slfr_pkg::CMD_BYTE, b);
    end
  endtask

  // stop sending, let every expected word arrive, then let the pipe settle
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [slfr_pkg::TICK_W-1:0] value);
    cfg_valid   <= 1'b1;
    cfg_timeout <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    timeout_reg = value;
  endtask

  // field extremes, hunting, minimal frame and oversized lengths
  task automatic test_directed_frames();
    send_word(slfr_pkg::CMD_BYTE, 8'h00);
    send_word(slfr_pkg::CMD_BYTE, 8'hFF);
    send_word(slfr_pkg::CMD_TICK, 8'hFF);
    send_word(slfr_pkg::CMD_BYTE, slfr_pkg::SYNC_BYTE);
    send_word(slfr_pkg::CMD_BYTE, 8'h00);
    send_word(slfr_pkg::CMD_BYTE, 8'hFF);
    send_word(slfr_pkg::CMD_BYTE, slfr_pkg::SYNC_BYTE);
    send_word(slfr_pkg::CMD_BYTE, 8'h00);
    send_word(slfr_pkg::CMD_BYTE, 8'h00);
    send_word(slfr_pkg::CMD_BYTE, 8'h55);
    send_word(slfr_pkg::CMD_BYTE, 8'hFF);
    // length 1017 pushes the total one past the buffer
    send_word(slfr_pkg::CMD_BYTE, slfr_pkg::SYNC_BYTE);
    send_word(slfr_pkg::CMD_BYTE, 8'h11);
    send_word(slfr_pkg::CMD_BYTE, 8'h22);
    send_word(slfr_pkg::CMD_BYTE, 8'h33);
    send_word(slfr_pkg::CMD_BYTE, 8'hF9);
    send_word(slfr_pkg::CMD_BYTE, 8'h03);
    send_word(slfr_pkg::CMD_BYTE, 8'h04);
    // largest declared length
    send_word(slfr_pkg::CMD_BYTE, slfr_pkg::SYNC_BYTE);
    send_word(slfr_pkg::CMD_BYTE, 8'h80);
    send_word(slfr_pkg::CMD_BYTE, 8'h01);
    send_word(slfr_pkg::CMD_BYTE, 8'hFE);
    send_word(slfr_pkg::CMD_BYTE, 8'hFF);
    send_word(slfr_pkg::CMD_BYTE, 8'hFF);
  endtask

  // timeout at the reset value of the register
  task automatic test_default_timeout();
    repeat (1000) send_tick();
  endtask

  // a declared total equal to the buffer size is kept; the partial frame
  // is cleared by the first timeout of the next test
  task automatic test_length_limit();
    send_frame(MAX_FRAME - slfr_pkg::FRAME_BASE_LEN, 12, 0);
  endtask

  // zero timeout: every tick expires, also mid-frame
  task automatic test_timeout_zero();
    wait_quiet();
    write_timeout('0);
    send_tick();
    send_word(slfr_pkg::CMD_BYTE, slfr_pkg::SYNC_BYTE);
    send_word(slfr_pkg::CMD_BYTE, 8'h05);
    send_word(slfr_pkg::CMD_BYTE, 8'h06);
    send_tick();
    send_word(slfr_pkg::CMD_BYTE, 8'h33);
    send_tick();
  endtask

  // max timeout, then lowered below elapsed; frame end restarts the timer,
  // an abort does not
  task automatic test_timeout_lowered();
    wait_quiet();
    write_timeout('1);
    repeat (10) send_tick();
    send_word(slfr_pkg::CMD_BYTE, slfr_pkg::SYNC_BYTE);
    send_word(slfr_pkg::CMD_BYTE, 8'h01);
    send_word(slfr_pkg::CMD_BYTE, 8'h02);
    wait_quiet();
    write_timeout(32'd3);
    send_tick();
    send_word(slfr_pkg::CMD_BYTE, 8'h44);
    repeat (3) send_tick();
    repeat (2) send_tick();
    send_frame(0, MAX_FRAME, 0);
    repeat (3) send_tick();
    repeat (2) send_tick();
    send_frame(16'hFFFF, MAX_FRAME, 0);
    send_tick();
  endtask

  // random frames, broken frames, noise and ticks over several timeouts
  task automatic test_random_traffic();
    int target;
    int pick;
    int unsigned len;
    for (int phase = 0; phase < 6; phase++) begin
      wait_quiet();
      case (phase)
        0:       write_timeout(32'($urandom));
        1:       write_timeout(32'd1);
        5:       write_timeout(32'($urandom_range(40, 300)));
        default: write_timeout(32'($urandom_range(15, 400)));
      endcase
      gaps_on = (phase != 5);
      target  = sent_items + 120;
      while (sent_items < target) begin
        if (phase != 5 && $urandom_range(0, 9) == 0) gaps_on = !gaps_on;
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          len = $urandom_range(0, 99);
          if (len < 80)      len = $urandom_range(0, 24);
          else if (len < 92) len = $urandom_range(25, 200);
          else len = $urandom_range(MAX_FRAME - slfr_pkg::FRAME_BASE_LEN + 1, 65535);
          send_frame(len, MAX_FRAME, 4);
        end else if (pick < 75) begin
          send_frame($urandom_range(0, 30), $urandom_range(1, 12), 4);
        end else if (pick < 87) begin
          send_word(slfr_pkg::CMD_BYTE, 8'($urandom));
        end else begin
          send_tick();
        end
      end
    end
  endtask

  // random receiver stall bursts
  always @(posedge clk) begin
    if (rst || !gaps_on) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0 && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 11);
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // result word checker
  always @(posedge clk) begin : check_words
    slfr_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      checked_words++;
      if (expected_words.size() == 0) begin
        flag_error($sformatf("unexpected word: data %02h pos %0d end %0b abort %0b tmo %0b",
                             got_data, got_pos, got_end, got_abort, got_tmo));
      end else begin
        want = expected_words.pop_front();
        if (got_data !== want.data_byte || got_pos !== want.position ||
            got_end !== want.frame_end || got_abort !== want.frame_abort ||
            got_tmo !== want.timed_out) begin
          flag_error($sformatf({"word %0d: expected data %02h pos %0d end %0b abort %0b ",
                                "tmo %0b, got data %02h pos %0d end %0b abort %0b tmo %0b"},
                               checked_words, want.data_byte, want.position, want.frame_end,
                               want.frame_abort, want.timed_out, got_data, got_pos,
                               got_end, got_abort, got_tmo));
        end
      end
    end
  end

  // hang watchdog: cycles without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      hang_cycles <= 0;
    end else if (hang_cycles >= HANG_LIMIT) begin
      $display("Timeout: no progress for %0d cycles", HANG_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      hang_cycles <= hang_cycles + 1;
    end
  end

  initial begin
    frame_fill  = 0;
    frame_total = slfr_pkg::FRAME_BASE_LEN;
    len_lo      = '0;
    tick_count  = '0;
    timeout_reg = slfr_pkg::TIMEOUT_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_frames();
    test_default_timeout();
    test_length_limit();
    test_timeout_zero();
    test_timeout_lowered();
    test_random_traffic();

    wait_quiet();
    if (expected_words.size() != 0)
      flag_error($sformatf("%0d expected words never arrived", expected_words.size()));
    $display("Covered %0d input words and %0d result words: %0d frames, %0d aborts, %0d timeouts",
             sent_items, checked_words, n_frames, n_aborts, n_timeouts);
    $display("Timeout settings: reset value, zero, one, three, all ones and random values");
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d errors", n_errors);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
design/slfr_pkg.sv
design/slfr_frame_ctl.sv
design/slfr_result_reg.sv
design/sync_length_frame_receiver.sv
tb/tb_top.sv
